/* rtl/fatn_pkg.sv */
// Shared types and constants for the fault-aware tree neighbor block.
// Used by fatn_csr, fatn_ctrl, fatn_dp and the top level.
`default_nettype none

package fatn_pkg;

   // Largest group size the tree walk covers; a larger count is clamped.
   localparam logic [6:0] MAX_PROCS = 7'd64;

   // Register reset values
   localparam logic [6:0]  COUNT_RESET = 7'd64;
   localparam logic [63:0] MASK_RESET  = 64'd0;

   // Register select, taken from the 8-byte register slot
   localparam logic CSR_IDX_COUNT = 1'b0;
   localparam logic CSR_IDX_MASK  = 1'b1;

   // Parent code for "no live ancestor"
   localparam logic [6:0] NO_PARENT = 7'h7F;

   typedef struct packed {
      logic load_query;  // capture query, start parent walk at the query
      logic par_up;      // step the walk pointer to its parent
      logic par_set;     // record parent of the walk pointer as the answer
      logic start_kids;  // point at the left child of the query
      logic descend;     // failed node: move to its left child
      logic sibling;     // left child done: move to its right sibling
      logic climb;       // right child done: move to its parent
      logic push;        // live child found: stash it, release older one
      logic finish;      // walk done: release final beat
   } fatn_cmd_type;

   typedef struct packed {
      logic is_root;         // walk pointer is rank 0
      logic parent_live;     // parent of the walk pointer has not failed
      logic in_range;        // walk pointer below the process count
      logic node_dead;       // walk pointer marked failed
      logic node_left;       // walk pointer is a left child
      logic parent_is_query; // parent of the walk pointer is the query
      logic have_pend;       // a found child waits in the stash
      logic out_free;        // output register can take a beat now
   } fatn_sts_type;

endpackage

`default_nettype wire

/* rtl/fatn_csr.sv */
// Configuration registers: process count and failed-rank mask, APB-style access.
// Depends on fatn_pkg for reset values and register select codes.
`default_nettype none

module fatn_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic      [63:0] csr_prdata,
   output logic             csr_pready,
   output logic      [6:0]  process_count,
   output logic      [63:0] failed_mask
);

   logic [6:0]  count_ff, count_in;
   logic [63:0] mask_ff, mask_in;
   logic        wr_go;

   assign csr_pready = 1'b1;
   assign wr_go      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      count_in = count_ff;
      mask_in  = mask_ff;
      if (wr_go) begin
         unique case (csr_paddr[3])
            fatn_pkg::CSR_IDX_COUNT: count_in = csr_pwdata[6:0];
            fatn_pkg::CSR_IDX_MASK:  mask_in  = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         fatn_pkg::CSR_IDX_COUNT: csr_prdata = {57'd0, count_ff};
         fatn_pkg::CSR_IDX_MASK:  csr_prdata = mask_ff;
         default:                 csr_prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= fatn_pkg::COUNT_RESET;
         mask_ff  <= fatn_pkg::MASK_RESET;
      end else begin
         count_ff <= count_in;
         mask_ff  <= mask_in;
      end
   end

   assign process_count = count_ff;
   assign failed_mask   = mask_ff;

endmodule

`default_nettype wire

/* rtl/fatn_ctrl.sv */
// Sequencer for the ancestor walk and the depth-first descendant walk.
// Depends on fatn_pkg for the command and status structs.
`default_nettype none

module fatn_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire fatn_pkg::fatn_sts_type sts,
   output fatn_pkg::fatn_cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PARENT,
      ST_VISIT,
      ST_ADVANCE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_query = 1'b1;
               state_in       = ST_PARENT;
            end
         end
         ST_PARENT: begin
            if (sts.is_root) begin
               cmd.start_kids = 1'b1;
               state_in       = ST_VISIT;
            end else if (sts.parent_live) begin
               cmd.par_set    = 1'b1;
               cmd.start_kids = 1'b1;
               state_in       = ST_VISIT;
            end else begin
               cmd.par_up = 1'b1;
            end
         end
         ST_VISIT: begin
            if (sts.in_range && sts.node_dead) begin
               cmd.descend = 1'b1;
            end else if (sts.in_range) begin
               // hold until an older stashed child can go out
               if (!sts.have_pend || sts.out_free) begin
                  cmd.push = 1'b1;
                  state_in = ST_ADVANCE;
               end
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            if (sts.node_left) begin
               cmd.sibling = 1'b1;
               state_in    = ST_VISIT;
            end else if (sts.parent_is_query) begin
               state_in = ST_FINISH;
            end else begin
               cmd.climb = 1'b1;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_query |=> (state_ff == ST_PARENT))
      else $error("query load did not start the parent walk");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && sts.out_free |=> req_tready)
      else $error("finished query did not return to idle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADVANCE) && !sts.node_left && sts.parent_is_query
         |=> (state_ff == ST_FINISH))
      else $error("walk passed the query subtree boundary");

endmodule

`default_nettype wire

/* rtl/fatn_dp.sv */
// Datapath: query and walk registers, child stash and the result output register.
// Depends on fatn_pkg for the command and status structs and constants.
`default_nettype none

module fatn_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fatn_pkg::fatn_cmd_type cmd,
   output fatn_pkg::fatn_sts_type      sts,
   input  wire logic [5:0]             query_rank,
   input  wire logic [6:0]             process_count,
   input  wire logic [63:0]            failed_mask,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [6:0]             parent_rank,
   output logic      [5:0]             child_rank,
   output logic                        has_child,
   output logic                        last_child
);

   logic [5:0] q_ff;
   logic [7:0] node_ff, node_in;
   logic [6:0] parent_ff;
   logic [5:0] pend_ff;
   logic       have_pend_ff, have_pend_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] out_parent_ff;
   logic [5:0] out_child_ff;
   logic       out_has_ff;
   logic       out_last_ff;

   logic [7:0] node_dec;
   logic [6:0] pnode;
   logic [6:0] eff_cnt;
   logic       emit_go;

   assign node_dec = node_ff - 8'd1;
   assign pnode    = node_dec[7:1];
   assign eff_cnt  = (process_count > fatn_pkg::MAX_PROCS) ? fatn_pkg::MAX_PROCS
                                                           : process_count;

   assign sts.is_root         = (node_ff == 8'd0);
   assign sts.parent_live     = !failed_mask[pnode[5:0]];
   assign sts.in_range        = (node_ff < {1'b0, eff_cnt});
   assign sts.node_dead       = failed_mask[node_ff[5:0]];
   assign sts.node_left       = node_ff[0];
   assign sts.parent_is_query = (pnode == {1'b0, q_ff});
   assign sts.have_pend       = have_pend_ff;
   assign sts.out_free        = !rsp_valid_ff || rsp_tready;

   // a push releases the older stashed child; finish releases the last beat
   assign emit_go = (cmd.push && have_pend_ff) || cmd.finish;

   always_comb begin
      node_in = node_ff;
      if (cmd.load_query) begin
         node_in = {2'b00, query_rank};
      end else if (cmd.start_kids) begin
         node_in = {1'b0, q_ff, 1'b1};
      end else if (cmd.descend) begin
         node_in = {node_ff[6:0], 1'b1};
      end else if (cmd.sibling) begin
         node_in = node_ff + 8'd1;
      end else if (cmd.climb || cmd.par_up) begin
         node_in = {1'b0, pnode};
      end
   end

   always_comb begin
      have_pend_in = have_pend_ff;
      if (cmd.load_query || cmd.finish) begin
         have_pend_in = 1'b0;
      end else if (cmd.push) begin
         have_pend_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_pend_ff <= have_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      if (cmd.load_query) begin
         q_ff      <= query_rank;
         parent_ff <= fatn_pkg::NO_PARENT;
      end else if (cmd.par_set) begin
         parent_ff <= {1'b0, pnode[5:0]};
      end
      if (cmd.push) begin
         pend_ff <= node_ff[5:0];
      end
      if (emit_go) begin
         out_parent_ff <= parent_ff;
         out_child_ff  <= have_pend_ff ? pend_ff : 6'd0;
         out_has_ff    <= have_pend_ff;
         out_last_ff   <= cmd.finish;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign parent_rank = out_parent_ff;
   assign child_rank  = out_child_ff;
   assign has_child   = out_has_ff;
   assign last_child  = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      emit_go |-> sts.out_free)
      else $error("result beat overwrote an unaccepted beat");

   assert property (@(posedge clock) disable iff (reset)
      cmd.descend |-> (sts.in_range && sts.node_dead))
      else $error("descent from a live or absent node");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_has_ff) |-> out_last_ff)
      else $error("childless beat not marked last");

   assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (node_ff < 8'd64) && !failed_mask[node_ff[5:0]])
      else $error("stashed child is failed or out of range");

endmodule

`default_nettype wire

/* rtl/fault_aware_tree_neighbors_top.sv */
// Top level: fault-aware binary heap tree neighbor lookup.
// Depends on fatn_pkg, fatn_csr, fatn_ctrl and fatn_dp.
//
//   channel  dir  handshake                 payload
//   req      in   req_tvalid / req_tready   tdata: query_rank
//   rsp      out  rsp_tvalid / rsp_tready   tdata: parent_rank, child_rank;
//                                           tuser: has_child; tlast: last_child
//   csr      in   psel/penable/pready       process_count @0x0, failed_mask @0x8
//
// One query at a time: the query is accepted, then ancestors are checked one by one (at most 6),
// then each child slot of every descended node takes a visit and an advance, and a final
// step closes out the last beat.
// The single node pointer stepping through the subtree sets the rate.
// A stalled rsp channel holds the walk only when a child or final beat must go out.
// Synchronous reset restores process_count 64 and an empty failed mask.
`default_nettype none

module fault_aware_tree_neighbors_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [5:0] query_rank, [7:6] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [6:0] parent_rank, [12:7] child_rank, [15:13] 0
   output logic      [0:0]  rsp_tuser,   // [0] has_child
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic      [63:0] csr_prdata,
   output logic             csr_pready
);

   fatn_pkg::fatn_cmd_type cmd;
   fatn_pkg::fatn_sts_type sts;
   logic [6:0]  process_count;
   logic [63:0] failed_mask;
   logic [6:0]  parent_rank;
   logic [5:0]  child_rank;
   logic        has_child;
   logic        last_child;

   fatn_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .process_count (process_count),
      .failed_mask   (failed_mask)
   );

   fatn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fatn_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .query_rank    (req_tdata[5:0]),
      .process_count (process_count),
      .failed_mask   (failed_mask),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .parent_rank   (parent_rank),
      .child_rank    (child_rank),
      .has_child     (has_child),
      .last_child    (last_child)
   );

   assign rsp_tdata = {3'b000, child_rank, parent_rank};
   assign rsp_tuser = has_child;
   assign rsp_tlast = last_child;

endmodule

`default_nettype wire
